// File: sv/svm_pkg.sv
`default_nettype none
package svm_pkg;

	// Fixed field widths
	localparam int ADDR_W = 14;
	localparam int LEN_W  = 15;
	localparam int DATA_W = 16;

	// Request codes on req_type
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_FRAME = 2'd2;

	// Clip bound, 0xffff/2
	localparam logic signed [DATA_W-1:0] CLIP_LIMIT = 16'sd32767;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_START,
		CMD_FRAME
	} cmd_kind_t;

	// Classified command, address already wrapped into the sample memory
	typedef struct packed {
		cmd_kind_t          kind;
		logic [ADDR_W-1:0]  addr;
		logic [DATA_W-1:0]  value;
		logic [LEN_W-1:0]   length;
		logic               stereo;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VOICE,
		ST_FIRST,
		ST_SECOND,
		ST_EMIT
	} mix_state_t;

endpackage
`default_nettype wire

// File: sv/svm_front.sv
`default_nettype none
module svm_front #(
	parameter int SAMPLE_WORDS = 16384
) (
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    req_type,
	input  wire logic [svm_pkg::ADDR_W-1:0]    mem_addr,
	input  wire logic signed [svm_pkg::DATA_W-1:0] sample_value,
	input  wire logic [svm_pkg::ADDR_W-1:0]    voice_start,
	input  wire logic [svm_pkg::LEN_W-1:0]     voice_length,
	input  wire logic                          voice_stereo,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output svm_pkg::cmd_t                      push_cmd
);
	import svm_pkg::*;

	// Reduce an address modulo the memory size by restoring subtraction
	function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
		logic [31:0] x;
		x = 32'(a);
		for (int k = 6; k >= 0; k--) begin
			if (x >= (32'(SAMPLE_WORDS) << k)) begin
				x = x - (32'(SAMPLE_WORDS) << k);
			end
		end
		return x[ADDR_W-1:0];
	endfunction

	logic keep;

	// Classify the transaction; drop unknown codes and empty starts
	always_comb begin
		push_cmd        = '0;
		push_cmd.value  = sample_value;
		push_cmd.length = voice_length;
		push_cmd.stereo = voice_stereo;
		keep            = 1'b0;
		case (req_type)
			REQ_LOAD: begin
				keep          = 1'b1;
				push_cmd.kind = CMD_LOAD;
				push_cmd.addr = wrap_addr(mem_addr);
			end
			REQ_START: begin
				keep          = (voice_length != '0);
				push_cmd.kind = CMD_START;
				push_cmd.addr = wrap_addr(voice_start);
			end
			REQ_FRAME: begin
				keep          = 1'b1;
				push_cmd.kind = CMD_FRAME;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready   = push_ready;
	assign push_valid = in_valid && keep;

endmodule
`default_nettype wire

// File: sv/svm_queue.sv
`default_nettype none
module svm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire svm_pkg::cmd_t push_cmd,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output svm_pkg::cmd_t      pop_cmd
);
	import svm_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push_fire;
	logic       pop_fire;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_fire) wr_ptr_q <= ~wr_ptr_q;
			if (pop_fire) rd_ptr_q <= ~rd_ptr_q;
			if (push_fire && !pop_fire) count_q <= count_q + 2'd1;
			else if (pop_fire && !push_fire) count_q <= count_q - 2'd1;
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (push_fire) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

// File: sv/svm_back.sv
`default_nettype none
module svm_back #(
	parameter int NUM_VOICES   = 8,
	parameter int SAMPLE_WORDS = 16384
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pop_valid,
	output logic                                   pop_ready,
	input  wire svm_pkg::cmd_t                     pop_cmd,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [svm_pkg::DATA_W-1:0]      left_sample,
	output logic signed [svm_pkg::DATA_W-1:0]      right_sample
);
	import svm_pkg::*;

	localparam int AW   = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
	localparam int VW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int SUMW = DATA_W + VW + 1;
	localparam logic [VW-1:0] LAST_V  = VW'(NUM_VOICES - 1);
	localparam logic [AW-1:0] LAST_AD = AW'(SAMPLE_WORDS - 1);

	mix_state_t state_q, state_d;

	// Voice table
	logic [NUM_VOICES-1:0] busy_q;
	logic [AW-1:0]         pos_q    [NUM_VOICES];
	logic [LEN_W-1:0]      lim_q    [NUM_VOICES];
	logic                  stereo_q [NUM_VOICES];

	// Sample memory
	logic [DATA_W-1:0] sample_mem [SAMPLE_WORDS];
	logic signed [DATA_W-1:0] rd_q;

	logic [VW-1:0]          v_q;
	logic signed [SUMW-1:0] left_q, right_q;
	logic signed [DATA_W-1:0] out_left_q, out_right_q;
	logic                   out_valid_q;

	logic cur_busy, cur_stereo, cur_has_words;
	logic [AW-1:0] cur_pos, next_pos;

	logic          free_found;
	logic [VW-1:0] free_idx;

	logic rd_en, step_en, free_en, start_en, wr_en;
	logic clear_sums, add_left, add_right, load_out, v_inc;

	logic signed [SUMW-1:0] rd_ext;

	assign cur_busy      = busy_q[v_q];
	assign cur_stereo    = stereo_q[v_q];
	assign cur_has_words = (lim_q[v_q] != '0);
	assign cur_pos       = pos_q[v_q];
	assign next_pos      = (cur_pos == LAST_AD) ? '0 : cur_pos + AW'(1);
	assign rd_ext        = {{(SUMW-DATA_W){rd_q[DATA_W-1]}}, rd_q};

	// Find the lowest free voice
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_VOICES - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = VW'(i);
			end
		end
	end

	// Clip a sum to the symmetric range
	function automatic logic signed [DATA_W-1:0] clip(input logic signed [SUMW-1:0] s);
		if (s >= SUMW'(CLIP_LIMIT)) return CLIP_LIMIT;
		if (s <= -SUMW'(CLIP_LIMIT)) return -CLIP_LIMIT;
		return s[DATA_W-1:0];
	endfunction

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Sequence commands and the per-voice walk of a frame
	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		rd_en      = 1'b0;
		step_en    = 1'b0;
		free_en    = 1'b0;
		start_en   = 1'b0;
		wr_en      = 1'b0;
		clear_sums = 1'b0;
		add_left   = 1'b0;
		add_right  = 1'b0;
		load_out   = 1'b0;
		v_inc      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					case (pop_cmd.kind)
						CMD_LOAD:  wr_en = 1'b1;
						CMD_START: start_en = free_found;
						CMD_FRAME: begin
							clear_sums = 1'b1;
							state_d    = ST_VOICE;
						end
						default: ;
					endcase
				end
			end
			ST_VOICE: begin
				if (cur_busy && cur_has_words) begin
					rd_en   = 1'b1;
					step_en = 1'b1;
					state_d = ST_FIRST;
				end else begin
					free_en = cur_busy;
					if (v_q == LAST_V) state_d = ST_EMIT;
					else v_inc = 1'b1;
				end
			end
			ST_FIRST: begin
				add_left = 1'b1;
				if (cur_stereo && cur_has_words) begin
					rd_en   = 1'b1;
					step_en = 1'b1;
					state_d = ST_SECOND;
				end else begin
					add_right = !cur_stereo;
					free_en   = !cur_has_words;
					if (v_q == LAST_V) state_d = ST_EMIT;
					else begin
						v_inc   = 1'b1;
						state_d = ST_VOICE;
					end
				end
			end
			ST_SECOND: begin
				add_right = 1'b1;
				free_en   = !cur_has_words;
				if (v_q == LAST_V) state_d = ST_EMIT;
				else begin
					v_inc   = 1'b1;
					state_d = ST_VOICE;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port: one write or one registered read
	always_ff @(posedge clk) begin
		if (wr_en) sample_mem[AW'(pop_cmd.addr)] <= pop_cmd.value;
		if (rd_en) rd_q <= signed'(sample_mem[cur_pos]);
	end

	// Busy bits and voice counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			v_q    <= '0;
		end else begin
			if (start_en) busy_q[free_idx] <= 1'b1;
			if (free_en) busy_q[v_q] <= 1'b0;
			if (clear_sums) v_q <= '0;
			else if (v_inc) v_q <= v_q + VW'(1);
		end
	end

	// Voice position, remaining words and mode
	always_ff @(posedge clk) begin
		if (start_en) begin
			pos_q[free_idx]    <= AW'(pop_cmd.addr);
			lim_q[free_idx]    <= pop_cmd.length;
			stereo_q[free_idx] <= pop_cmd.stereo;
		end
		if (step_en) begin
			pos_q[v_q] <= next_pos;
			lim_q[v_q] <= lim_q[v_q] - LEN_W'(1);
		end
	end

	// Accumulate the frame sums
	always_ff @(posedge clk) begin
		if (clear_sums) begin
			left_q  <= '0;
			right_q <= '0;
		end else begin
			if (add_left) left_q <= left_q + rd_ext;
			if (add_right) right_q <= right_q + rd_ext;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_left_q  <= clip(left_q);
			out_right_q <= clip(right_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = out_left_q;
	assign right_sample = out_right_q;

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && pop_valid && pop_cmd.kind == CMD_LOAD) |=> state_q == ST_IDLE)
		else $error("load command left idle");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == ST_VOICE || state_q == ST_FIRST))
		else $error("memory read outside voice walk");

	a_voice_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q <= LAST_V)
		else $error("voice index out of range");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |-> state_q == ST_IDLE)
		else $error("command taken while busy");

endmodule
`default_nettype wire

// File: sv/sample_voice_mixer_unit.sv
`default_nettype none
// Channel | Handshake          | Payload
// input   | in_valid/in_ready  | req_type, mem_addr, sample_value, voice_start,
//         |                    | voice_length, voice_stereo
// output  | out_valid/out_ready| left_sample, right_sample (one per frame request)
//
// Load and start requests are handled in the back end's idle state; a frame
// request walks every voice in turn through the single sample memory port,
// which reads at most one word per cycle, and then emits the clipped sums.
// arst_n clears the voice busy bits, queue and output flag; memory is not cleared.
// A two-entry command queue keeps accepting input while a frame is mixed, until
// it is full, and the output register holds a finished frame until out_ready.
module sample_voice_mixer_unit #(
	parameter int NUM_VOICES   = 8,
	parameter int SAMPLE_WORDS = 16384
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        req_type,
	input  wire logic [svm_pkg::ADDR_W-1:0]        mem_addr,
	input  wire logic signed [svm_pkg::DATA_W-1:0] sample_value,
	input  wire logic [svm_pkg::ADDR_W-1:0]        voice_start,
	input  wire logic [svm_pkg::LEN_W-1:0]         voice_length,
	input  wire logic                              voice_stereo,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [svm_pkg::DATA_W-1:0]      left_sample,
	output logic signed [svm_pkg::DATA_W-1:0]      right_sample
);
	import svm_pkg::*;

	logic push_valid, push_ready, pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;

	svm_front #(
		.SAMPLE_WORDS(SAMPLE_WORDS)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.mem_addr     (mem_addr),
		.sample_value (sample_value),
		.voice_start  (voice_start),
		.voice_length (voice_length),
		.voice_stereo (voice_stereo),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	svm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	svm_back #(
		.NUM_VOICES   (NUM_VOICES),
		.SAMPLE_WORDS (SAMPLE_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

endmodule
`default_nettype wire

// File: dv/tb_sample_voice_mixer_unit.sv
`timescale 1ns / 1ps
module tb_sample_voice_mixer_unit;
	import svm_pkg::*;

	localparam int VOICES      = 8;
	localparam int MEM_WORDS   = 1 << ADDR_W;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	// Code outside the defined request set, ignored by the block
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic signed [DATA_W-1:0] left;
		logic signed [DATA_W-1:0] right;
	} frame_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               req_type;
	logic [ADDR_W-1:0]        mem_addr;
	logic signed [DATA_W-1:0] sample_value;
	logic [ADDR_W-1:0]        voice_start;
	logic [LEN_W-1:0]         voice_length;
	logic                     voice_stereo;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] left_sample;
	logic signed [DATA_W-1:0] right_sample;

	// Mixer state as predicted from accepted transactions
	logic signed [DATA_W-1:0] pcm_mem [MEM_WORDS];
	bit                       pcm_written [MEM_WORDS];
	bit                       voice_on [VOICES];
	bit [ADDR_W-1:0]          voice_pos [VOICES];
	bit [LEN_W-1:0]           voice_left [VOICES];
	bit                       voice_st [VOICES];

	frame_t pending_frames[$];
	int     mismatch_count;
	bit     steady;
	bit     hold_request;

	sample_voice_mixer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.mem_addr     (mem_addr),
		.sample_value (sample_value),
		.voice_start  (voice_start),
		.voice_length (voice_length),
		.voice_stereo (voice_stereo),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Read the next word of a voice and advance it
	function automatic int take_word(int v);
		int w;
		w = pcm_mem[voice_pos[v]];
		voice_pos[v] = voice_pos[v] + 1'b1;
		voice_left[v] = voice_left[v] - 1'b1;
		return w;
	endfunction

	function automatic logic signed [DATA_W-1:0] clip_pcm(int s);
		if (s >= CLIP_LIMIT)
			return CLIP_LIMIT;
		if (s <= -CLIP_LIMIT)
			return -CLIP_LIMIT;
		return DATA_W'(s);
	endfunction

	// Advance the mixer state by one accepted transaction
	function automatic void mix_request(logic [1:0] req, logic [ADDR_W-1:0] addr,
			logic signed [DATA_W-1:0] value, logic [ADDR_W-1:0] start,
			logic [LEN_W-1:0] length, logic stereo);
		int     left_sum;
		int     right_sum;
		int     w;
		bit     claimed;
		frame_t frame;
		left_sum  = 0;
		right_sum = 0;
		claimed   = 1'b0;
		case (req)
			REQ_LOAD: begin
				pcm_mem[addr]     = value;
				pcm_written[addr] = 1'b1;
			end
			REQ_START: begin
				if (length != 0) begin
					for (int v = 0; v < VOICES; v++) begin
						if (!claimed && !voice_on[v]) begin
							voice_on[v]   = 1'b1;
							voice_pos[v]  = start;
							voice_left[v] = length;
							voice_st[v]   = stereo;
							claimed       = 1'b1;
						end
					end
				end
			end
			REQ_FRAME: begin
				for (int v = 0; v < VOICES; v++) begin
					if (voice_on[v]) begin
						if (voice_left[v] != 0) begin
							if (voice_st[v]) begin
								left_sum += take_word(v);
								if (voice_left[v] != 0)
									right_sum += take_word(v);
							end else begin
								w = take_word(v);
								left_sum  += w;
								right_sum += w;
							end
						end
						if (voice_left[v] == 0)
							voice_on[v] = 1'b0;
					end
				end
				frame.left  = clip_pcm(left_sum);
				frame.right = clip_pcm(right_sum);
				pending_frames.push_back(frame);
			end
			default: begin
			end
		endcase
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic send_item(logic [1:0] req, logic [ADDR_W-1:0] addr,
			logic signed [DATA_W-1:0] value, logic [ADDR_W-1:0] start,
			logic [LEN_W-1:0] length, logic stereo);
		if (!steady && $urandom_range(99) < 10) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid     = 1'b1;
		req_type     = req;
		mem_addr     = addr;
		sample_value = value;
		voice_start  = start;
		voice_length = length;
		voice_stereo = stereo;
		do @(posedge clk); while (!in_ready);
		mix_request(req, addr, value, start, length, stereo);
	endtask

	function automatic logic signed [DATA_W-1:0] random_word();
		case ($urandom_range(7))
			0: return CLIP_LIMIT;
			1: return {1'b1, {(DATA_W-1){1'b0}}};
			2: return DATA_W'($urandom_range(200)) - 16'sd100;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	task automatic send_load(logic [ADDR_W-1:0] addr, logic signed [DATA_W-1:0] value);
		send_item(REQ_LOAD, addr, value, ADDR_W'($urandom), LEN_W'($urandom), 1'($urandom));
	endtask

	task automatic send_start(logic [ADDR_W-1:0] start, logic [LEN_W-1:0] length,
			logic stereo);
		send_item(REQ_START, ADDR_W'($urandom), DATA_W'($urandom), start, length, stereo);
	endtask

	task automatic send_unknown();
		send_item(REQ_UNUSED, ADDR_W'($urandom), DATA_W'($urandom), ADDR_W'($urandom),
			LEN_W'($urandom), 1'($urandom));
	endtask

	// Load every word the next frame will read that has not been written yet
	task automatic send_frame();
		int               n;
		logic [ADDR_W-1:0] a;
		for (int v = 0; v < VOICES; v++) begin
			if (voice_on[v] && voice_left[v] != 0) begin
				n = (voice_st[v] && voice_left[v] >= 2) ? 2 : 1;
				for (int k = 0; k < n; k++) begin
					a = voice_pos[v] + ADDR_W'(k);
					if (!pcm_written[a])
						send_load(a, random_word());
				end
			end
		end
		send_item(REQ_FRAME, ADDR_W'($urandom), DATA_W'($urandom), ADDR_W'($urandom),
			LEN_W'($urandom), 1'($urandom));
	endtask

	// Drop valid and wait for every predicted frame
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_request();
		int               pick;
		logic [LEN_W-1:0] length;
		pick = $urandom_range(99);
		if (pick < 5) begin
			send_unknown();
		end else if (pick < 25) begin
			send_load(ADDR_W'($urandom), random_word());
		end else if (pick < 55) begin
			pick = $urandom_range(99);
			if (pick < 3)
				length = '0;
			else if (pick < 75)
				length = LEN_W'($urandom_range(1, 8));
			else
				length = LEN_W'($urandom_range(9, 64));
			send_start(ADDR_W'($urandom), length, 1'($urandom));
		end else begin
			send_frame();
		end
	endtask

	// Unknown code and a frame with no voice playing
	task automatic test_idle_requests();
		send_unknown();
		send_frame();
		wait_drained();
	endtask

	// Two voices at the top of memory wrap to address 0 and drive both clip bounds
	task automatic test_wrap_and_clip();
		send_load('1, CLIP_LIMIT);
		send_load('0, {1'b1, {(DATA_W-1){1'b0}}});
		send_start('1, LEN_W'(2), 1'b0);
		send_start('1, LEN_W'(2), 1'b0);
		send_frame();
		send_frame();
		send_start('0, LEN_W'(1), 1'b0);
		send_frame();
		send_start(ADDR_W'(5), '0, 1'b0);
		send_frame();
		wait_drained();
	endtask

	// Stereo voice with an odd word count ends on a left-only frame
	task automatic test_odd_stereo_tail();
		send_start(ADDR_W'(200), LEN_W'(3), 1'b1);
		send_frame();
		send_frame();
		send_frame();
		wait_drained();
	endtask

	// Long wrapping voice, then fill every voice and overflow with one more start
	task automatic test_voice_exhaustion();
		send_start('1, '1, 1'b1);
		for (int i = 0; i < VOICES; i++)
			send_start(ADDR_W'($urandom), LEN_W'($urandom_range(2, 6)), 1'($urandom));
		repeat (4) send_frame();
		wait_drained();
	endtask

	task automatic test_steady_stream(int count);
		steady = 1'b1;
		repeat (count) random_request();
		wait_drained();
		steady = 1'b0;
	endtask

	// Hold off the result side while frames keep coming
	task automatic test_output_backpressure();
		hold_request = 1'b1;
		repeat (3) send_start(ADDR_W'($urandom), LEN_W'(40), 1'($urandom));
		repeat (12) send_frame();
		wait_drained();
	endtask

	task automatic test_random_mix(int count);
		repeat (count) random_request();
		wait_drained();
	endtask

	// Result side ready, with random stalls and one long hold-off
	initial begin : result_ready
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			out_ready = steady || ($urandom_range(99) >= 10);
		end
	end

	// Compare each frame transaction with the oldest prediction
	always @(posedge clk) begin : check_frames
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frames.size() == 0) begin
				$error("frame result with no request pending: left %0d, right %0d",
					left_sample, right_sample);
				mismatch_count++;
			end else begin
				want = pending_frames.pop_front();
				if (left_sample !== want.left) begin
					$error("left_sample: expected %0d, got %0d", want.left, left_sample);
					mismatch_count++;
				end
				if (right_sample !== want.right) begin
					$error("right_sample: expected %0d, got %0d", want.right, right_sample);
					mismatch_count++;
				end
			end
		end
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("sample_voice_mixer_unit: mismatch");
		$finish;
	end

	initial begin : stimulus
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_LOAD;
		mem_addr       = '0;
		sample_value   = '0;
		voice_start    = '0;
		voice_length   = '0;
		voice_stereo   = 1'b0;
		steady         = 1'b0;
		hold_request   = 1'b0;
		mismatch_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_requests();
		test_wrap_and_clip();
		test_odd_stereo_tail();
		test_voice_exhaustion();
		test_steady_stream(40);
		test_output_backpressure();
		test_random_mix(70);

		@(negedge clk);
		in_valid = 1'b0;
		wait_drained();
		repeat (3 * VOICES + 12) @(posedge clk);
		if (mismatch_count == 0)
			$display("sample_voice_mixer_unit: match");
		else
			$display("sample_voice_mixer_unit: mismatch");
		$finish;
	end

endmodule
